/* hdl/tcci_pkg.sv */
// ----------------------------------------------------------------------------
// tcci_pkg: shared types and constants of the console control interpreter
// Control codes, register indexes, reset values and the attribute and
// result records that pass between the step logic and the top level.
// ----------------------------------------------------------------------------
package tcci_pkg;

    // default screen limits
    localparam int MAX_COLS_DEFAULT = 128;
    localparam int MAX_ROWS_DEFAULT = 64;

    // configuration register indexes (word address)
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_DIAG    = 2'd2;

    // configuration reset values
    localparam logic [7:0] COLUMNS_RESET = 8'd40;
    localparam logic [6:0] ROWS_RESET    = 7'd30;
    localparam logic [2:0] COLOR_RESET   = 3'd7;

    // first byte that is not a control code
    localparam logic [7:0] CC_LIMIT       = 8'h20;

    // control codes
    localparam logic [7:0] CC_HOME        = 8'h01;
    localparam logic [7:0] CC_BOLD_ON     = 8'h02;
    localparam logic [7:0] CC_ATTR_OFF    = 8'h03;
    localparam logic [7:0] CC_BOLD_OFF    = 8'h04;
    localparam logic [7:0] CC_BLINK_ON    = 8'h05;
    localparam logic [7:0] CC_BLINK_OFF   = 8'h06;
    localparam logic [7:0] CC_BELL        = 8'h07;
    localparam logic [7:0] CC_BACKSPACE   = 8'h08;
    localparam logic [7:0] CC_TAB         = 8'h09;
    localparam logic [7:0] CC_NEWLINE     = 8'h0A;
    localparam logic [7:0] CC_CLEAR       = 8'h0C;
    localparam logic [7:0] CC_RETURN      = 8'h0D;
    localparam logic [7:0] CC_COLOR_FIRST = 8'h0E;
    localparam logic [7:0] CC_COLOR_LAST  = 8'h15;
    localparam logic [7:0] CC_RIGHT       = 8'h16;
    localparam logic [7:0] CC_UP          = 8'h17;
    localparam logic [7:0] CC_DOWN        = 8'h18;
    localparam logic [7:0] CC_CURSOR_ON   = 8'h19;
    localparam logic [7:0] CC_LEFT        = 8'h1A;
    localparam logic [7:0] CC_CURSOR_OFF  = 8'h1D;
    localparam logic [7:0] CC_INVERSE_ON  = 8'h1E;
    localparam logic [7:0] CC_INVERSE_OFF = 8'h1F;

    // text attributes
    typedef struct packed {
        logic       bold;
        logic [2:0] color;
        logic       inverse;
        logic       blink;
        logic       cursor_en;
    } attr_t;

    // one result word
    typedef struct packed {
        logic       write_cell;
        logic [6:0] cell_col;
        logic [5:0] cell_row;
        logic [9:0] cell_code;
        logic [3:0] color_index;
        logic       scroll_up;
        logic       clear_screen;
        logic       ring_bell;
        logic [7:0] cursor_col_out;
        logic [5:0] cursor_row_out;
        logic       cursor_shown;
    } result_t;

endpackage

/* hdl/tcci_step.sv */
// ----------------------------------------------------------------------------
// tcci_step: one console byte against the cursor and attribute state
// Clamps the screen size and cursor, decodes the control codes or forms the
// cell write, and gives the next cursor, the next attributes and the result.
// ----------------------------------------------------------------------------
module tcci_step #(
    parameter int MAX_COLS = tcci_pkg::MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = tcci_pkg::MAX_ROWS_DEFAULT,
    parameter int CW       = $clog2(MAX_COLS + 1),
    parameter int RW       = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1
) (
    input  logic [7:0]      char_code,
    input  logic [7:0]      columns,
    input  logic [6:0]      rows,
    input  logic            diag_mode,
    input  logic [CW-1:0]   cur_col,
    input  logic [RW-1:0]   cur_row,
    input  tcci_pkg::attr_t cur_attr,
    output logic [CW-1:0]   next_col,
    output logic [RW-1:0]   next_row,
    output tcci_pkg::attr_t next_attr,
    output tcci_pkg::result_t result
);

    localparam int NW = $clog2(MAX_ROWS + 1);

    logic [CW-1:0] cols;
    logic [NW-1:0] nrows;
    logic [CW:0]   col_in;
    logic [NW-1:0] row_in;

    // screen size held inside its limits
    always_comb begin
        if (columns == 8'd0) begin
            cols = CW'(1);
        end else if ({1'b0, columns} > 9'(MAX_COLS)) begin
            cols = CW'(MAX_COLS);
        end else begin
            cols = CW'(columns);
        end
        if (rows == 7'd0) begin
            nrows = NW'(1);
        end else if ({2'b00, rows} > 9'(MAX_ROWS)) begin
            nrows = NW'(MAX_ROWS);
        end else begin
            nrows = NW'(rows);
        end
    end

    // cursor pulled back onto the screen
    always_comb begin
        if (NW'(cur_row) >= nrows) begin
            row_in = nrows - NW'(1);
        end else begin
            row_in = NW'(cur_row);
        end
        if (cur_col > cols) begin
            col_in = {1'b0, cols};
        end else begin
            col_in = {1'b0, cur_col};
        end
    end

    // code decode and cell write
    always_comb begin
        logic [CW:0]     col_n;
        logic [NW-1:0]   row_n;
        logic [CW:0]     cols_x;
        logic [CW:0]     tab_col;
        logic            last_row;
        logic            wc;
        logic [CW:0]     wcol;
        logic [NW-1:0]   wrow;
        logic [9:0]      code;
        logic            scr;
        logic            clr;
        logic            bell;
        tcci_pkg::attr_t attr_n;

        col_n    = col_in;
        row_n    = row_in;
        cols_x   = {1'b0, cols};
        tab_col  = (col_in & ~((CW+1)'(7))) + (CW+1)'(8);
        last_row = (row_in + NW'(1)) >= nrows;
        wc       = 1'b0;
        wcol     = '0;
        wrow     = '0;
        code     = '0;
        scr      = 1'b0;
        clr      = 1'b0;
        bell     = 1'b0;
        attr_n   = cur_attr;

        if (!diag_mode && (char_code < tcci_pkg::CC_LIMIT)) begin
            unique case (char_code) inside
                tcci_pkg::CC_HOME: begin
                    col_n = '0;
                    row_n = '0;
                end
                tcci_pkg::CC_BOLD_ON:   attr_n.bold = 1'b1;
                tcci_pkg::CC_ATTR_OFF: begin
                    attr_n.bold    = 1'b0;
                    attr_n.inverse = 1'b0;
                    attr_n.blink   = 1'b0;
                end
                tcci_pkg::CC_BOLD_OFF:  attr_n.bold  = 1'b0;
                tcci_pkg::CC_BLINK_ON:  attr_n.blink = 1'b1;
                tcci_pkg::CC_BLINK_OFF: attr_n.blink = 1'b0;
                tcci_pkg::CC_BELL:      bell = 1'b1;
                tcci_pkg::CC_BACKSPACE: begin
                    if (col_in != '0) begin
                        col_n = col_in - (CW+1)'(1);
                    end else begin
                        col_n = cols_x - (CW+1)'(1);
                        if (row_in != '0) begin
                            row_n = row_in - NW'(1);
                        end
                    end
                end
                tcci_pkg::CC_TAB: begin
                    col_n = tab_col;
                    if (tab_col >= cols_x) begin
                        col_n = '0;
                        if (last_row) begin
                            scr = 1'b1;
                        end else begin
                            row_n = row_in + NW'(1);
                        end
                    end
                end
                tcci_pkg::CC_NEWLINE: begin
                    if (last_row) begin
                        scr = 1'b1;
                    end else begin
                        row_n = row_in + NW'(1);
                    end
                end
                tcci_pkg::CC_CLEAR: begin
                    col_n = '0;
                    row_n = '0;
                    clr   = 1'b1;
                end
                tcci_pkg::CC_RETURN: col_n = '0;
                [tcci_pkg::CC_COLOR_FIRST:tcci_pkg::CC_COLOR_LAST]: begin
                    attr_n.color = 3'(char_code - tcci_pkg::CC_COLOR_FIRST);
                end
                tcci_pkg::CC_RIGHT: begin
                    if ((col_in + (CW+1)'(1)) < cols_x) begin
                        col_n = col_in + (CW+1)'(1);
                    end
                end
                tcci_pkg::CC_UP: begin
                    if (row_in != '0) begin
                        row_n = row_in - NW'(1);
                    end
                end
                tcci_pkg::CC_DOWN: begin
                    if (!last_row) begin
                        row_n = row_in + NW'(1);
                    end
                end
                tcci_pkg::CC_CURSOR_ON: attr_n.cursor_en = 1'b1;
                tcci_pkg::CC_LEFT: begin
                    if (col_in != '0) begin
                        col_n = col_in - (CW+1)'(1);
                    end
                end
                tcci_pkg::CC_CURSOR_OFF:  attr_n.cursor_en = 1'b0;
                tcci_pkg::CC_INVERSE_ON:  attr_n.inverse   = 1'b1;
                tcci_pkg::CC_INVERSE_OFF: attr_n.inverse   = 1'b0;
                default: ;
            endcase
        end else begin
            code = {cur_attr.blink, cur_attr.inverse, char_code};
            wc   = 1'b1;
            if (!diag_mode || (col_in >= cols_x)) begin
                // pending wrap taken first, then write and advance
                if (col_in >= cols_x) begin
                    col_n = '0;
                    if (last_row) begin
                        scr = 1'b1;
                    end else begin
                        row_n = row_in + NW'(1);
                    end
                end
                wcol  = col_n;
                wrow  = row_n;
                col_n = col_n + (CW+1)'(1);
            end else begin
                // diagnostic: write, then wrap straight away
                wcol  = col_in;
                wrow  = row_in;
                col_n = col_in + (CW+1)'(1);
                if (col_n >= cols_x) begin
                    col_n = '0;
                    if (last_row) begin
                        scr = 1'b1;
                        if (row_in != '0) begin
                            wrow = row_in - NW'(1);
                        end else begin
                            wc   = 1'b0;
                            wcol = '0;
                            code = '0;
                        end
                    end else begin
                        row_n = row_in + NW'(1);
                    end
                end
            end
        end

        next_col  = CW'(col_n);
        next_row  = RW'(row_n);
        next_attr = attr_n;

        result.write_cell     = wc;
        result.cell_col       = 7'(wcol);
        result.cell_row       = 6'(wrow);
        result.cell_code      = code;
        result.color_index    = {attr_n.bold, attr_n.color};
        result.scroll_up      = scr;
        result.clear_screen   = clr;
        result.ring_bell      = bell;
        result.cursor_col_out = 8'(col_n);
        result.cursor_row_out = 6'(row_n);
        result.cursor_shown   = attr_n.cursor_en;
    end

endmodule

/* hdl/text_console_control_interpreter.sv */
// ----------------------------------------------------------------------------
// text_console_control_interpreter: console byte to screen commands
// Input register, step logic and result register; one byte per cycle while m_ready stays high.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one console byte per word (s_char_code), valid/ready.
//   m_ channel: one result word per byte: cell write, scroll, clear, bell,
//   colour index and the new cursor position and visibility.
//   APB port: columns at 0x0, rows at 0x4, diag_mode at 0x8; write only
//   while no byte is in flight. Reads return the register value.
// Data path and throughput
//   An accepted byte is captured in the input register, passes the step logic
//   and is captured in the result register, from which its result is offered.
//   One byte per cycle is sustained while m_ready stays high; the cursor and
//   attribute registers close their loop through the step logic.
// Reset and stalls
//   Reset empties both registers, sets 40 columns, 30 rows, normal mode,
//   cursor at home and hidden, white text without bold, inverse or blink.
//   When the receiver holds m_ready low the result word waits; one more byte
//   is taken into the input register, then s_ready drops until it moves on.
// ----------------------------------------------------------------------------
module text_console_control_interpreter #(
    parameter int MAX_COLS = tcci_pkg::MAX_COLS_DEFAULT,
    parameter int MAX_ROWS = tcci_pkg::MAX_ROWS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_cell,
    output logic [6:0]  m_cell_col,
    output logic [5:0]  m_cell_row,
    output logic [9:0]  m_cell_code,
    output logic [3:0]  m_color_index,
    output logic        m_scroll_up,
    output logic        m_clear_screen,
    output logic        m_ring_bell,
    output logic [7:0]  m_cursor_col_out,
    output logic [5:0]  m_cursor_row_out,
    output logic        m_cursor_shown
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;

    logic [7:0]        columns_reg;
    logic [6:0]        rows_reg;
    logic              diag_reg;
    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic              out_valid_reg;
    tcci_pkg::result_t out_res_reg;
    logic [CW-1:0]     col_reg;
    logic [RW-1:0]     row_reg;
    tcci_pkg::attr_t   attr_reg;

    logic              cfg_write;
    logic              step_fire;
    logic [CW-1:0]     col_next;
    logic [RW-1:0]     row_next;
    tcci_pkg::attr_t   attr_next;
    tcci_pkg::result_t res_next;

    // configuration writes
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= tcci_pkg::COLUMNS_RESET;
            rows_reg    <= tcci_pkg::ROWS_RESET;
            diag_reg    <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                tcci_pkg::REG_COLUMNS: columns_reg <= pwdata[7:0];
                tcci_pkg::REG_ROWS:    rows_reg    <= pwdata[6:0];
                tcci_pkg::REG_DIAG:    diag_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // configuration reads
    always_comb begin
        unique case (paddr[3:2])
            tcci_pkg::REG_COLUMNS: prdata = {24'd0, columns_reg};
            tcci_pkg::REG_ROWS:    prdata = {25'd0, rows_reg};
            tcci_pkg::REG_DIAG:    prdata = {31'd0, diag_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // handshake between input register and result register
    assign step_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
        end
    end

    // step logic
    tcci_step #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CW       (CW),
        .RW       (RW)
    ) u_step (
        .char_code (in_char_reg),
        .columns   (columns_reg),
        .rows      (rows_reg),
        .diag_mode (diag_reg),
        .cur_col   (col_reg),
        .cur_row   (row_reg),
        .cur_attr  (attr_reg),
        .next_col  (col_next),
        .next_row  (row_next),
        .next_attr (attr_next),
        .result    (res_next)
    );

    // cursor and attribute state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg            <= '0;
            row_reg            <= '0;
            attr_reg.bold      <= 1'b0;
            attr_reg.color     <= tcci_pkg::COLOR_RESET;
            attr_reg.inverse   <= 1'b0;
            attr_reg.blink     <= 1'b0;
            attr_reg.cursor_en <= 1'b0;
        end else if (step_fire) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            attr_reg <= attr_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            out_res_reg <= res_next;
        end
    end

    // result ports
    assign m_valid          = out_valid_reg;
    assign m_write_cell     = out_res_reg.write_cell;
    assign m_cell_col       = out_res_reg.cell_col;
    assign m_cell_row       = out_res_reg.cell_row;
    assign m_cell_code      = out_res_reg.cell_code;
    assign m_color_index    = out_res_reg.color_index;
    assign m_scroll_up      = out_res_reg.scroll_up;
    assign m_clear_screen   = out_res_reg.clear_screen;
    assign m_ring_bell      = out_res_reg.ring_bell;
    assign m_cursor_col_out = out_res_reg.cursor_col_out;
    assign m_cursor_row_out = out_res_reg.cursor_row_out;
    assign m_cursor_shown   = out_res_reg.cursor_shown;

endmodule
